// ===== src/d2q_pkg.sv =====
package d2q_pkg;

  localparam int unsigned DefFracBits = 32;
  localparam int unsigned DefIntBits  = 32;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_OVF   = 2'd1,
    ST_SMALL = 2'd2
  } status_e;

endpackage

// ===== src/double_to_q32_32_converter.sv =====
// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid/in_ready  | double_bits (64b)
// out     | output    | out_valid/out_ready| fixed_value (64b signed), status (2b)
//
// Four register stages: decode, shift, round/check, output. One word is
// taken every cycle unless the output stalls. Ready is passed back through the
// pipeline combinationally: a stage advances when the one after it is empty
// or advancing. Reset clears all valid bits; payload registers keep no reset.
module double_to_q32_32_converter #(
  parameter int unsigned FracBits = d2q_pkg::DefFracBits,
  parameter int unsigned IntBits  = d2q_pkg::DefIntBits
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [63:0]        double_bits_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [63:0] fixed_value_o,
  output logic [1:0]         status_o
);
  import d2q_pkg::*;

  localparam int TopRaw = int'(IntBits) - 1 + int'(FracBits);
  localparam int Top    = (TopRaw > 63) ? 63 : TopRaw;
  localparam logic [63:0] Lim = 64'd1 << Top;

  // stage valids and advance enables
  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;
  assign en4 = !v4_q || out_ready_i;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_ready_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  // stage 1: field decode, k = exp - 1075 + FracBits, or -1074 + FracBits for subnormals (13b signed)
  logic        neg1_q, spec1_q, zero1_q;
  logic [52:0] mant1_q;
  logic signed [12:0] k1_q;
  always_ff @(posedge clk_i) begin
    if (en1) begin
      neg1_q  <= double_bits_i[63];
      spec1_q <= &double_bits_i[62:52];
      zero1_q <= (double_bits_i[62:0] == 63'd0);
      mant1_q <= {|double_bits_i[62:52], double_bits_i[51:0]};
      k1_q    <= (double_bits_i[62:52] == 11'd0) ?
                 13'(-1074 + int'(FracBits)) :
                 $signed({2'b00, double_bits_i[62:52]}) - 13'sd1075
                 + 13'(FracBits);
    end
  end

  // stage 2: shift; right shift keeps remainder info, left shift checks length
  logic        neg2_q, spec2_q, zero2_q, small2_q, big2_q;
  logic [63:0] q2_q;
  logic        half2_q, sticky2_q;
  logic [5:0]  sh_r;
  logic [116:0] wide;
  logic [52:0]  low_mask;
  always_comb begin
    sh_r = 6'(-k1_q);
    wide = {64'd0, mant1_q} << k1_q[5:0];
    low_mask = (53'd1 << (sh_r - 6'd1)) - 53'd1;
  end
  always_ff @(posedge clk_i) begin
    if (en2) begin
      neg2_q   <= neg1_q;
      spec2_q  <= spec1_q;
      zero2_q  <= zero1_q;
      small2_q <= (k1_q < 0) && ((k1_q <= -13'sd53) || ((mant1_q >> sh_r) == 53'd0));
      big2_q   <= (k1_q >= 0) && ((k1_q > 13'sd63) || (wide[116:64] != 53'd0));
      if (k1_q < 0) begin
        q2_q      <= 64'(mant1_q >> sh_r);
        half2_q   <= mant1_q[sh_r - 6'd1];
        sticky2_q <= |(mant1_q & low_mask);
      end else begin
        q2_q      <= wide[63:0];
        half2_q   <= 1'b0;
        sticky2_q <= 1'b0;
      end
    end
  end

  // stage 3: round and range check
  logic [1:0]  st3_q;
  logic        neg3_q;
  logic [63:0] mag3_q;
  logic        rnd;
  logic [63:0] mag;
  logic        ovf;
  always_comb begin
    rnd = neg2_q ? (half2_q && sticky2_q) : half2_q;
    mag = q2_q + {63'd0, rnd};
    if (neg2_q)
      ovf = (mag > Lim) || (q2_q >= Lim && (half2_q || sticky2_q)) || (rnd && mag == 64'd0);
    else
      ovf = (mag >= Lim) || (rnd && mag == 64'd0);
    ovf = ovf || big2_q;
  end
  always_ff @(posedge clk_i) begin
    if (en3) begin
      neg3_q <= neg2_q;
      mag3_q <= mag;
      if (spec2_q)       st3_q <= ST_OVF;
      else if (zero2_q)  st3_q <= ST_OK;
      else if (small2_q) st3_q <= ST_SMALL;
      else if (ovf)      st3_q <= ST_OVF;
      else               st3_q <= ST_OK;
    end
  end

  // stage 4: sign apply and output word
  logic [63:0] val4_q;
  logic [1:0]  st4_q;
  always_ff @(posedge clk_i) begin
    if (en4) begin
      st4_q  <= st3_q;
      val4_q <= (st3_q != ST_OK) ? 64'd0 :
                (neg3_q ? (64'd0 - mag3_q) : mag3_q);
    end
  end

  assign out_valid_o   = v4_q;
  assign fixed_value_o = $signed(val4_q);
  assign status_o      = st4_q;

`ifndef SYNTHESIS
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> fixed_value_o == 64'sd0)
    else $error("error word carries nonzero value");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(fixed_value_o))
    else $error("stalled output changed");
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o != 2'd3)
    else $error("bad status code");
`endif
endmodule

// ===== dv/d2q_checker.sv =====
// Watches both channels, predicts each result and compares in order.
module d2q_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [63:0]        double_bits_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic signed [63:0] fixed_value_i,
  input  logic [1:0]         status_i,
  output int                 fail_count_o,
  output int                 pending_o
);
  import d2q_pkg::*;

  localparam int FracBits = 32;
  localparam int IntBits  = 32;

  typedef struct packed {
    logic [63:0] value;
    status_e     status;
  } fixed_res_t;

  fixed_res_t expected_q[$];

  // Exact conversion on sign, exponent and mantissa; half rounds up.
  function automatic fixed_res_t to_fixed(logic [63:0] bits);
    fixed_res_t  r;
    logic        neg;
    int          ex, k, top, sh, len;
    logic [63:0] man, mant, lim, q, rem, half, mag;
    neg = bits[63];
    ex  = int'(bits[62:52]);
    man = {12'd0, bits[51:0]};
    top = IntBits - 1 + FracBits;
    if (top > 63) top = 63;
    lim = 64'd1 << top;
    r.value  = '0;
    r.status = ST_OK;
    if (ex == 'h7FF) begin
      r.status = ST_OVF;
    end else if (ex != 0 || man != 0) begin
      if (ex == 0) begin
        mant = man;
        k = -1074 + FracBits;
      end else begin
        mant = man | (64'd1 << 52);
        k = ex - 1075 + FracBits;
      end
      if (k < 0) begin
        sh = -k;
        if (sh >= 53 || (mant >> sh) == 0) begin
          r.status = ST_SMALL;
        end else begin
          half = 64'd1 << (sh - 1);
          q    = mant >> sh;
          rem  = mant & ((64'd1 << sh) - 1);
          mag  = q + ((neg ? rem > half : rem >= half) ? 64'd1 : 64'd0);
          if (neg ? (mag > lim || (q >= lim && rem != 0)) : mag >= lim)
            r.status = ST_OVF;
          else
            r.value = neg ? -mag : mag;
        end
      end else begin
        len = 0;
        for (int b = 0; b < 64; b++) if (mant[b]) len = b + 1;
        if (len + k > top + 1) begin
          r.status = ST_OVF;
        end else begin
          mag = mant << k;
          if (neg ? mag > lim : mag >= lim) r.status = ST_OVF;
          else r.value = neg ? -mag : mag;
        end
      end
    end
    return r;
  endfunction

  assign pending_o = expected_q.size();

  // Queue predictions on input words, compare on output words.
  always @(posedge clk_i or negedge rst_ni) begin
    fixed_res_t exp_r;
    int         errs;
    if (!rst_ni) begin
      fail_count_o <= 0;
      expected_q.delete();
    end else begin
      errs = 0;
      if (in_valid_i && in_ready_i) expected_q.push_back(to_fixed(double_bits_i));
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $error("unexpected word: fixed_value %h status %0d", fixed_value_i, status_i);
          errs++;
        end else begin
          exp_r = expected_q.pop_front();
          if (fixed_value_i !== exp_r.value) begin
            $error("fixed_value: expected %h actual %h", exp_r.value, fixed_value_i);
            errs++;
          end
          if (status_i !== exp_r.status) begin
            $error("status: expected %0d actual %0d", exp_r.status, status_i);
            errs++;
          end
        end
      end
      if (errs != 0) fail_count_o <= fail_count_o + errs;
    end
  end

endmodule

// ===== dv/testbench.sv =====
// Stimulus for the double to 32.32 converter; verdict from checker count.
module testbench;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [63:0]        double_bits_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [63:0] fixed_value_o;
  logic [1:0]         status_o;
  int                 fail_count, pending;
  int                 send_idle_pct = 0, recv_stall_pct = 0;

  always #1 clk_i = ~clk_i;

  double_to_q32_32_converter dut (.*);

  d2q_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .double_bits_i,
    .out_valid_i(out_valid_o), .out_ready_i, .fixed_value_i(fixed_value_o),
    .status_i(status_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  // Receiver stalls at random.
  always @(negedge clk_i) out_ready_i <= ($urandom_range(99) >= recv_stall_pct);

  // Send one word, with random idle cycles first.
  task automatic send_word(logic [63:0] bits);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    double_bits_i <= bits;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Random double biased toward exponents near the interesting range.
  function automatic logic [63:0] rand_double();
    logic [63:0] b;
    int          ex;
    b = {$urandom, $urandom};
    case ($urandom_range(9))
      0:       ex = $urandom_range(2047);
      1:       ex = 0;
      2:       ex = 2047;
      3:       ex = 1023 + 31;
      4:       ex = 1023 - 32 + $urandom_range(1);
      5: begin
        ex = 1023 - 33 + $urandom_range(20);
        b[51:0] = b[51:0] & ~((64'd1 << $urandom_range(51)) - 1);
        if ($urandom_range(1)) b[51:0] |= (64'd1 << $urandom_range(51));
      end
      default: ex = 1023 - 40 + $urandom_range(75);
    endcase
    b[62:52] = ex[10:0];
    return b;
  endfunction

  logic [63:0] directed_q[$] = '{
    64'h0000000000000000, 64'h8000000000000000, 64'h3FF0000000000000,
    64'hBFF0000000000000, 64'h7FF0000000000000, 64'hFFF0000000000000,
    64'h7FF8000000000001, 64'hFFFFFFFFFFFFFFFF, 64'h41E0000000000000,
    64'hC1E0000000000000, 64'hC1E0000000100000, 64'h41DFFFFFFFFFFFFF,
    64'hC1E0000000000001, 64'h3DF0000000000000, 64'hBDF0000000000000,
    64'h3DEFFFFFFFFFFFFF, 64'h0000000000000001, 64'h800FFFFFFFFFFFFF,
    64'h3DF8000000000000, 64'hBDF8000000000000, 64'h3DE0000000000000,
    64'h3FE0000000000000, 64'h7FEFFFFFFFFFFFFF, 64'h41DFFFFFFFFFFFFE
  };

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    foreach (directed_q[i]) send_word(directed_q[i]);
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        1:       begin send_idle_pct = 83; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 83; end
        3:       begin send_idle_pct = 25; recv_stall_pct = 25; end
        default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      endcase
      for (int n = 0; n < 190; n++) send_word(rand_double());
    end
    in_valid_i <= 1'b0;
    recv_stall_pct = 0;
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #400000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
